/* src/tpdf_dither_noise_shaping_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef TPDF_DITHER_NOISE_SHAPING_TOP_MACROS_SVH
`define TPDF_DITHER_NOISE_SHAPING_TOP_MACROS_SVH

// Checked at every clock edge outside reset.
`define TDNS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TDNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tdns_pkg.sv */
package tdns_pkg;

   localparam int SAMPLE_BITS_DEF = 32;
   localparam int RANDOM_BITS_DEF = 15;

   localparam int SAMPLE_W    = 32;
   localparam int RANDOM_W    = 15;
   localparam int OUT_W       = 24;
   localparam int WORD_BITS_W = 5;
   localparam int GAIN_W      = 16;
   localparam int ERROR_W     = 34;
   localparam int SHIFT_W     = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int GAIN_FRAC       = 14;
   localparam int ROUND_HALF      = 8192;
   localparam int WORD_BITS_RESET = 16;
   localparam int WORD_BITS_MIN   = 8;
   localparam int WORD_BITS_MAX   = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WORD_BITS    = 2'd0,
      CSR_SHAPING_GAIN = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [RANDOM_W-1:0]        random_value;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] quantized;
      logic                    clipped;
   } rsp_word_type;

   // Clamped word length, its quantizer shift and the shaping gain.
   typedef struct packed {
      logic [WORD_BITS_W-1:0] word_len;
      logic [SHIFT_W-1:0]     shift;
      logic [GAIN_W-1:0]      gain;
   } shaper_cfg_type;

endpackage

/* src/tdns_csr.sv */
module tdns_csr
   import tdns_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output shaper_cfg_type         cfg
);

   localparam int TOP_BITS = (SAMPLE_BITS < WORD_BITS_MAX) ? SAMPLE_BITS : WORD_BITS_MAX;

   logic [WORD_BITS_W-1:0] word_bits_ff, word_bits_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic [WORD_BITS_W-1:0] word_len;
   logic [SHIFT_W:0]       shift_full;

   assign csr_ready = 1'b1;

   always_comb begin
      word_bits_in = word_bits_ff;
      gain_in      = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WORD_BITS: begin
               word_bits_in = csr_data[WORD_BITS_W-1:0];
            end
            CSR_SHAPING_GAIN: begin
               gain_in = csr_data[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_bits_ff <= WORD_BITS_W'(WORD_BITS_RESET);
         gain_ff      <= '0;
      end else begin
         word_bits_ff <= word_bits_in;
         gain_ff      <= gain_in;
      end
   end

   always_comb begin
      if (word_bits_ff < WORD_BITS_W'(WORD_BITS_MIN)) begin
         word_len = WORD_BITS_W'(WORD_BITS_MIN);
      end else if (word_bits_ff > WORD_BITS_W'(TOP_BITS)) begin
         word_len = WORD_BITS_W'(TOP_BITS);
      end else begin
         word_len = word_bits_ff;
      end
   end

   assign shift_full   = (SHIFT_W+1)'(SAMPLE_BITS) - {1'b0, word_len};
   assign cfg.word_len = word_len;
   assign cfg.shift    = shift_full[SHIFT_W-1:0];
   assign cfg.gain     = gain_ff;

endmodule

/* src/tdns_shaper.sv */
module tdns_shaper
   import tdns_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_word_type   in_word,
   input  shaper_cfg_type cfg,
   output rsp_word_type   out_word
);

   localparam int FW  = ERROR_W + 2;
   localparam int PW  = FW + GAIN_W + 1;
   localparam int HW  = PW - GAIN_FRAC;
   localparam int VW  = ((SAMPLE_BITS > HW) ? SAMPLE_BITS : HW) + 2;
   localparam int TW  = VW + RANDOM_BITS + 2;
   localparam int SHW = $clog2(TW);

   localparam logic signed [VW:0] ERR_MAX = (VW+1)'((64'sd1 <<< (ERROR_W-1)) - 64'sd1);
   localparam logic signed [VW:0] ERR_MIN = ~ERR_MAX;

   logic [RANDOM_BITS-1:0]          prev_random_ff, prev_random_in;
   logic signed [ERROR_W-1:0]       error_recent_ff, error_recent_in;
   logic signed [ERROR_W-1:0]       error_older_ff, error_older_in;

   logic [RANDOM_BITS-1:0]          rnd;
   logic signed [SAMPLE_BITS-1:0]   smp;
   logic signed [FW-1:0]            fb;
   logic signed [GAIN_W:0]          gain_s;
   logic signed [PW-1:0]            prod;
   logic signed [HW-1:0]            shaped;
   logic signed [VW-1:0]            v;
   logic signed [RANDOM_BITS:0]     dith;
   logic [SHW-1:0]                  total_shift;
   logic signed [TW-1:0]            t;
   logic signed [TW-1:0]            t_shr;
   logic signed [VW-1:0]            q;
   logic signed [VW:0]              err;
   logic signed [VW-1:0]            hi;
   logic signed [VW-1:0]            lo;
   logic signed [VW-1:0]            qs;
   logic                            clip;

   assign rnd    = RANDOM_BITS'(in_word.random_value);
   assign smp    = $signed(in_word.sample[SAMPLE_BITS-1:0]);

   // shaped = round(gain * (2*e1 - e2) / 2^14), half up
   assign fb     = (FW'(error_recent_ff) <<< 1) - FW'(error_older_ff);
   assign gain_s = $signed({1'b0, cfg.gain});
   assign prod   = (PW'(fb) * PW'(gain_s)) + PW'(ROUND_HALF);
   assign shaped = $signed(prod[PW-1:GAIN_FRAC]);
   assign v      = VW'(shaped) + VW'(smp);

   // floor((v + LSB/2 + dither) / LSB), taken at LSB / 2^RANDOM_BITS resolution
   assign dith        = $signed({1'b0, rnd}) - $signed({1'b0, prev_random_ff});
   assign total_shift = SHW'(cfg.shift) + SHW'(RANDOM_BITS);
   assign t           = (TW'(v) <<< RANDOM_BITS)
                      + (TW'(dith) <<< cfg.shift)
                      + (TW'(1) <<< (total_shift - SHW'(1)));
   assign t_shr       = t >>> total_shift;
   assign q           = t_shr[VW-1:0];

   assign err = (VW+1)'(v) - ((VW+1)'(q) <<< cfg.shift);

   always_comb begin
      if (err > ERR_MAX) begin
         error_recent_in = ERR_MAX[ERROR_W-1:0];
      end else if (err < ERR_MIN) begin
         error_recent_in = ERR_MIN[ERROR_W-1:0];
      end else begin
         error_recent_in = err[ERROR_W-1:0];
      end
   end

   assign error_older_in = error_recent_ff;
   assign prev_random_in = rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_random_ff  <= '0;
         error_recent_ff <= '0;
         error_older_ff  <= '0;
      end else if (fire) begin
         prev_random_ff  <= prev_random_in;
         error_recent_ff <= error_recent_in;
         error_older_ff  <= error_older_in;
      end
   end

   // saturate to the word range
   assign hi = (VW'(1) <<< (cfg.word_len - WORD_BITS_W'(1))) - VW'(1);
   assign lo = ~hi;

   always_comb begin
      qs   = q;
      clip = 1'b0;
      if (q > hi) begin
         qs   = hi;
         clip = 1'b1;
      end else if (q < lo) begin
         qs   = lo;
         clip = 1'b1;
      end
   end

   assign out_word.quantized = qs[OUT_W-1:0];
   assign out_word.clipped   = clip;

endmodule

/* src/tpdf_dither_noise_shaping_top.sv */
// Accepted words pass from the input register through the shaper to the
// output register on rsp, one word per cycle unless rsp stalls; the
// error feedback (one multiply, dither add, quantizer shift) is combinational.
// Reset (synchronous, active high) empties both stages, clears the error
// and previous random state, and sets word_bits to 16 and shaping_gain to 0.
module tpdf_dither_noise_shaping_top
   import tdns_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic           in_valid_ff, in_valid_in;
   req_word_type   in_word_ff, in_word_in;
   logic           out_valid_ff, out_valid_in;
   rsp_word_type   out_word_ff, out_word_in;

   logic           out_free;
   logic           fire;
   logic           accept;
   shaper_cfg_type cfg;
   rsp_word_type   result;

   tdns_csr #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tdns_shaper #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .RANDOM_BITS (RANDOM_BITS)
   ) u_shaper (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .in_word  (in_word_ff),
      .cfg      (cfg),
      .out_word (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign in_word_in   = accept ? req_data : in_word_ff;
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);
   assign out_word_in  = fire ? result : out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

/* src/tdns_checker.sv */
`include "tpdf_dither_noise_shaping_top_macros.svh"

module tdns_checker
   import tdns_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   `TDNS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled rsp word changed or dropped")
   `TDNS_ASSERT(a_no_stall_when_empty, clock, reset, !rsp_valid |-> !req_stall, "req stalled with empty output")
   `TDNS_ASSERT(a_clip_range, clock, reset, rsp_valid && rsp_data.clipped |-> rsp_data.quantized >= 24'sd127 || rsp_data.quantized <= -24'sd128, "clipped word not at a range limit")
   `TDNS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

bind tpdf_dither_noise_shaping_top tdns_checker u_tdns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/sv/tb_tpdf_dither_noise_shaping_top.sv */
module tb_tpdf_dither_noise_shaping_top;
   import tdns_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int PIPE_LATENCY  = 2;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 244;
   localparam int DIRECTED_ROWS = 26;
   localparam longint ERR_HI    = (longint'(1) <<< (ERROR_W - 1)) - 1;
   localparam longint ERR_LO    = -ERR_HI - 1;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      row_kind_type            kind;
      csr_index_type           index;
      logic [CSR_DATA_W-1:0]   value;
      req_word_type            word;
      logic                    fixed;
      rsp_word_type            want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shaper state and registers as the block should hold them
   logic [WORD_BITS_W-1:0] cfg_word_bits = WORD_BITS_W'(WORD_BITS_RESET);
   longint                 cfg_gain = 0;
   longint                 prev_random = 0;
   longint                 err_recent = 0;
   longint                 err_older = 0;

   rsp_word_type dithered_q [$];
   rsp_word_type due_word;
   int           fail_count = 0;
   int           cycles = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;

   int unsigned phase_bits [PHASES] = '{16, 8, 24, 12, 31, 0, 0, 20};
   int unsigned phase_gain [PHASES] = '{0, 16384, 32768, 65535, 8192, 40000, 0, 1};

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh0000_0000, 15'h0000}, 1'b1, '{24'sd0, 1'b0}},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh7FFF_FFFF, 15'h0000}, 1'b1, '{24'sd32767, 1'b1}},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh8000_0000, 15'h0000}, 1'b1, '{-24'sd32768, 1'b0}},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh8000_0000, 15'h7FFF}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh7FFF_FFFF, 15'h0000}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh0000_0000, 15'h7FFF}, 1'b0, '0},
      '{ROW_CSR,  CSR_WORD_BITS, 16'hFFE0, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh7FFF_FFFF, 15'h3039}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh8000_0000, 15'h0000}, 1'b0, '0},
      '{ROW_CSR,  CSR_WORD_BITS, 16'h001F, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh1234_5678, 15'h0001}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh8000_0000, 15'h7FFF}, 1'b0, '0},
      '{ROW_CSR,  CSR_WORD_BITS, 16'h0018, '0, 1'b0, '0},
      '{ROW_CSR,  CSR_SHAPING_GAIN, 16'h8000, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh4000_0000, 15'h2AAA}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'shC000_0000, 15'h5555}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh7FFF_FFFF, 15'h0000}, 1'b0, '0},
      '{ROW_CSR,  CSR_SHAPING_GAIN, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh7FFF_FF00, 15'h7FFF}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh8000_0100, 15'h0000}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh0000_0001, 15'h0001}, 1'b0, '0},
      '{ROW_CSR,  CSR_WORD_BITS, 16'h0008, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh7FFF_FFFF, 15'h0000}, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh8000_0000, 15'h7FFF}, 1'b0, '0},
      '{ROW_CSR,  CSR_WORD_BITS, 16'h0007, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WORD_BITS, 16'h0, '{32'sh0100_0000, 15'h0100}, 1'b0, '0}
   };

   tpdf_dither_noise_shaping_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shaped, dithered and floored word; advances the feedback state
   function automatic rsp_word_type dither_quantize(req_word_type w);
      int     wlen;
      int     lsh;
      longint fb, v, qf, rem, num, q, err, hi, lo;
      rsp_word_type r;
      wlen = int'(cfg_word_bits);
      if (wlen < WORD_BITS_MIN) wlen = WORD_BITS_MIN;
      if (wlen > WORD_BITS_MAX) wlen = WORD_BITS_MAX;
      lsh = SAMPLE_W - wlen;
      fb = 2 * err_recent - err_older;
      v = longint'(w.sample) + ((fb * cfg_gain + ROUND_HALF) >>> GAIN_FRAC);
      qf = v >>> lsh;
      rem = v - (qf <<< lsh);
      num = (rem <<< RANDOM_W) + (longint'(1) <<< (lsh + RANDOM_W - 1))
         + ((longint'({1'b0, w.random_value}) - prev_random) <<< lsh);
      q = qf + (num >>> (lsh + RANDOM_W));
      err = v - (q <<< lsh);
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
      err_older = err_recent;
      err_recent = err;
      prev_random = longint'({1'b0, w.random_value});
      hi = (longint'(1) <<< (wlen - 1)) - 1;
      lo = -hi - 1;
      r.clipped = 1'b0;
      if (q > hi) begin
         q = hi;
         r.clipped = 1'b1;
      end
      if (q < lo) begin
         q = lo;
         r.clipped = 1'b1;
      end
      r.quantized = q[OUT_W-1:0];
      return r;
   endfunction

   task automatic send_word(input req_word_type w, input logic fixed, input rsp_word_type want);
      rsp_word_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      predicted = dither_quantize(w);
      dithered_q.push_back(fixed ? want : predicted);
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_valid <= 1'b0;
      while (dithered_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WORD_BITS: cfg_word_bits = value[WORD_BITS_W-1:0];
         CSR_SHAPING_GAIN: cfg_gain = longint'({1'b0, value});
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      idle_pct = (mode == IDLE_SENDER) ? 80 : (mode == IDLE_BOTH) ? 6 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 80 : (mode == IDLE_BOTH) ? 6 : 0;
   endtask

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dithered_q.size() == 0) begin
            $error("unexpected word: quantized %0d clipped %0b",
                   rsp_data.quantized, rsp_data.clipped);
            fail_count++;
         end else begin
            due_word = dithered_q.pop_front();
            if (rsp_data.quantized !== due_word.quantized) begin
               $error("quantized: expected %0d, actual %0d",
                      due_word.quantized, rsp_data.quantized);
               fail_count++;
            end
            if (rsp_data.clipped !== due_word.clipped) begin
               $error("clipped: expected %0b, actual %0b",
                      due_word.clipped, rsp_data.clipped);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_word_type w;
      int unsigned  pick;
      int unsigned  wb;
      int unsigned  gain;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_words();
            csr_write(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wb = (ph == 6) ? $urandom_range(0, 31) : phase_bits[ph];
         gain = (ph == 6) ? $urandom_range(0, 65535) : phase_gain[ph];
         drain_words();
         csr_write(CSR_WORD_BITS, {11'($urandom), 5'(wb)});
         csr_write(CSR_SHAPING_GAIN, 16'(gain));
         set_idling(idle_mode_type'(ph % 4));
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // hold off until the pipe is empty once mid-run
            if (ph == 1 && i == PHASE_WORDS / 2) drain_words();
            pick = $urandom_range(0, 9);
            case (pick)
               0: w.sample = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
               1: w.sample = $urandom_range(0, 1)
                     ? 32'sh7FFF_FFFF - $signed($urandom_range(0, 1 << 20))
                     : 32'sh8000_0000 + $signed($urandom_range(0, 1 << 20));
               2: w.sample = $signed($urandom_range(0, 1 << 12)) - 2048;
               default: w.sample = $urandom;
            endcase
            pick = $urandom_range(0, 9);
            w.random_value = (pick == 0) ? 15'h0000 : (pick == 1) ? 15'h7FFF
               : 15'($urandom_range(0, 32767));
            send_word(w, 1'b0, '0);
         end
      end

      set_idling(IDLE_NONE);
      drain_words();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
